FILE: sv/heading_slew_with_lag_core_defines.svh
// ----------------------------------------------------------------------------
// heading slew assertion macros
// concurrent checks sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HEADING_SLEW_WITH_LAG_CORE_DEFINES_SVH
`define HEADING_SLEW_WITH_LAG_CORE_DEFINES_SVH

// same-cycle implication
`define HSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// shared widths, register codes and word types of the heading slew core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsl_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CFG_BITS      = 16;
    localparam int STEP_BITS     = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [STEP_BITS-1:0]  STEP_MAX   = '1;

    // register index codes, taken from paddr above the byte offset
    localparam logic REG_TURN_RATE  = 1'b0;
    localparam logic REG_LAG_BOUNDS = 1'b1;

    localparam logic [CFG_BITS-1:0] TURN_RATE_RST  = 16'd1024;
    localparam logic [CFG_BITS-1:0] LAG_BOUNDS_RST = 16'd4096;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        angle_t current_heading;
        angle_t target_heading;
    } hsl_in_t;

    typedef struct packed {
        angle_t new_heading;
        logic   reached;
    } hsl_out_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] turn_rate;
        logic [CFG_BITS-1:0] lag;
    } hsl_cfg_t;

    // per-word data carried alongside the divider
    typedef struct packed {
        angle_t cur;
        angle_t tgt;
        angle_t distance;
        logic   dec;
    } hsl_side_t;

    // flow control from the step pipeline back to the divider
    typedef struct packed {
        logic adv;
        logic take;
    } hsl_flow_t;

endpackage

FILE: sv/heading_slew_with_lag_core.sv
// ----------------------------------------------------------------------------
// heading_slew_with_lag_core
// Moves a binary-angle heading one slew step toward its target per word:
// the wrapped shorter distance is divided by lag bounds into a fixed-point
// ratio, the step is turn_rate*min(r+0.1,1) inside the bounds and
// turn_rate*r*r (saturated at 65535) outside, and the result snaps to the
// target when the step covers the distance. One word is accepted every
// cycle while in_ready is high; each word passes through the restoring
// divider, which resolves one quotient bit per stage, and then the step
// pipeline. Stalls on the output side fill pipeline gaps before the input
// is held. turn_rate and lag_bounds sit at byte addresses 0 and 4 of the
// APB port and must be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heading_slew_with_lag_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hsl_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [hsl_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [hsl_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hsl_pkg::hsl_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hsl_pkg::hsl_out_t                  out_data
);
    import hsl_pkg::*;

    hsl_cfg_t                           cfg;
    hsl_flow_t                          flow;
    logic                               q_valid;
    logic [ANGLE_BITS+FRAC_BITS-1:0]    q_ratio;
    hsl_side_t                          q_side;

    assign pready = 1'b1;

    hsl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    hsl_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .flow     (flow),
        .q_valid  (q_valid),
        .q_ratio  (q_ratio),
        .q_side   (q_side)
    );

    hsl_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ratio   (q_ratio),
        .q_side    (q_side),
        .flow      (flow),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: sv/hsl_cfg.sv
// ----------------------------------------------------------------------------
// hsl_cfg
// apb register file holding turn rate and lag bounds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hsl_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [hsl_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [hsl_pkg::APB_DATA_BITS-1:0]  prdata,
    output hsl_pkg::hsl_cfg_t                  cfg
);
    import hsl_pkg::*;

    logic [CFG_BITS-1:0] turn_rate_reg;
    logic [CFG_BITS-1:0] turn_rate_next;
    logic [CFG_BITS-1:0] lag_bounds_reg;
    logic [CFG_BITS-1:0] lag_bounds_next;
    logic                wr_en;
    logic                reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[APB_ADDR_BITS-1];

    always_comb
    begin
        turn_rate_next  = turn_rate_reg;
        lag_bounds_next = lag_bounds_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_TURN_RATE:  turn_rate_next  = pwdata[CFG_BITS-1:0];
                REG_LAG_BOUNDS: lag_bounds_next = pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_reg  <= TURN_RATE_RST;
            lag_bounds_reg <= LAG_BOUNDS_RST;
        end
        else
        begin
            turn_rate_reg  <= turn_rate_next;
            lag_bounds_reg <= lag_bounds_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_TURN_RATE:  prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, turn_rate_reg};
            REG_LAG_BOUNDS: prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, lag_bounds_reg};
            default:        prdata = '0;
        endcase
    end

    // zero lag bounds behaves as one
    assign cfg.turn_rate = turn_rate_reg;
    assign cfg.lag       = (lag_bounds_reg == '0) ? {{(CFG_BITS-1){1'b0}}, 1'b1}
                                                  : lag_bounds_reg;

endmodule

FILE: sv/hsl_div.sv
// ----------------------------------------------------------------------------
// hsl_div
// wrap and distance stage followed by a restoring divider, one quotient
// bit per pipeline stage, giving the lag ratio in fixed point
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heading_slew_with_lag_core_defines.svh"

module hsl_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  hsl_pkg::hsl_cfg_t                            cfg,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  hsl_pkg::hsl_in_t                             in_data,
    input  hsl_pkg::hsl_flow_t                           flow,
    output logic                                         q_valid,
    output logic [hsl_pkg::ANGLE_BITS+FRAC_BITS-1:0]     q_ratio,
    output hsl_pkg::hsl_side_t                           q_side
);
    import hsl_pkg::*;

    localparam int Q = ANGLE_BITS + FRAC_BITS;

    logic [Q:0]          v_reg;
    logic [Q:0]          v_next;
    logic [Q:0]          en;
    logic [Q:0]          take;

    logic [CFG_BITS-1:0] rem_reg  [Q+1];
    logic [CFG_BITS-1:0] rem_next [Q+1];
    logic [Q-1:0]        quo_reg  [Q+1];
    logic [Q-1:0]        quo_next [Q+1];
    hsl_side_t           side_reg  [Q+1];
    hsl_side_t           side_next [Q+1];

    angle_t              diff0;

    // a stage loads when empty or when the whole line moves
    assign en   = ~v_reg | {(Q+1){flow.adv}};
    assign take = {flow.take, en[Q:1]};

    // wrap stage: shorter distance and direction
    assign diff0 = in_data.current_heading - in_data.target_heading;

    assign side_next[0].cur      = in_data.current_heading;
    assign side_next[0].tgt      = in_data.target_heading;
    assign side_next[0].distance = (diff0 > ANGLE_HALF) ? (angle_t'(0) - diff0) : diff0;
    assign side_next[0].dec      = diff0 < ANGLE_HALF;
    assign rem_next[0]           = '0;
    assign quo_next[0]           = '0;
    assign v_next[0]             = en[0] ? in_valid : (v_reg[0] & ~take[0]);

    for (genvar s = 1; s <= Q; s++)
    begin : g_stage
        logic [CFG_BITS:0] trial;
        logic [CFG_BITS:0] diff;
        logic              nbit;
        logic              ge;

        // numerator is the distance followed by FRAC_BITS zeros
        if (s <= ANGLE_BITS)
        begin : g_bit
            assign nbit = side_reg[s-1].distance[ANGLE_BITS-s];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial        = {rem_reg[s-1], nbit};
        assign diff         = trial - {1'b0, cfg.lag};
        assign ge           = trial >= {1'b0, cfg.lag};
        assign rem_next[s]  = ge ? diff[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
        assign quo_next[s]  = {quo_reg[s-1][Q-2:0], ge};
        assign side_next[s] = side_reg[s-1];
        assign v_next[s]    = en[s] ? v_reg[s-1] : (v_reg[s] & ~take[s]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= Q; s++)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign in_ready = en[0];
    assign q_valid  = v_reg[Q];
    assign q_ratio  = quo_reg[Q];
    assign q_side   = side_reg[Q];

    `HSL_ASSERT_NOW(div_rem_below_lag, v_reg[Q], rem_reg[Q] < cfg.lag,
        "divider remainder not below lag bounds")
    `HSL_ASSERT_NEXT(div_last_holds, v_reg[Q] && !flow.take,
        v_reg[Q] && $stable(quo_reg[Q]) && $stable(side_reg[Q]),
        "divider output word changed while held")

endmodule

FILE: sv/hsl_step.sv
// ----------------------------------------------------------------------------
// hsl_step
// step size from the lag ratio (shared multiplier, split square product,
// sum and saturate) and the output register with snap to target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heading_slew_with_lag_core_defines.svh"

module hsl_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  hsl_pkg::hsl_cfg_t                          cfg,
    input  logic                                       q_valid,
    input  logic [hsl_pkg::ANGLE_BITS+FRAC_BITS-1:0]   q_ratio,
    input  hsl_pkg::hsl_side_t                         q_side,
    output hsl_pkg::hsl_flow_t                         flow,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output hsl_pkg::hsl_out_t                          out_data
);
    import hsl_pkg::*;

    localparam int Q        = ANGLE_BITS + FRAC_BITS;
    localparam int FX_W     = FRAC_BITS + 1;
    localparam int OPW      = FRAC_BITS + 8;
    localparam int PW       = CFG_BITS + OPW;
    localparam int T1W      = FRAC_BITS + STEP_BITS;
    localparam int H        = OPW / 2;
    localparam int HW       = OPW - H;
    localparam int PLW      = T1W + H;
    localparam int PHW      = T1W + HW;
    localparam int SW       = T1W + OPW;
    localparam int NS       = 4;
    localparam int TENTH_I  = ((1 << FRAC_BITS) + 5) / 10;

    localparam logic [FX_W-1:0] FX_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FX_W-1:0] FX_TENTH = FX_W'(TENTH_I);

    logic [NS-1:0]          v_reg;
    logic [NS-1:0]          v_next;
    logic [NS-1:0]          en;
    logic [NS-1:0]          take;
    logic                   adv;

    // stage 0: shared multiplier
    logic                   inner;
    logic [FX_W-1:0]        qsum;
    logic [FX_W-1:0]        qin;
    logic [OPW-1:0]         mop;
    logic [PW-1:0]          prod_next;
    logic [PW-1:0]          s0_prod_reg;
    logic                   s0_inner_reg;
    logic                   s0_big_reg;
    logic [OPW-1:0]         s0_rs_reg;
    hsl_side_t              s0_side_reg;

    // stage 1: split square product
    logic [T1W-1:0]         t1;
    logic [PLW-1:0]         pl_next;
    logic [PHW-1:0]         ph_next;
    logic                   sat1_next;
    logic [PLW-1:0]         s1_pl_reg;
    logic [PHW-1:0]         s1_ph_reg;
    logic                   s1_inner_reg;
    logic                   s1_sat_reg;
    logic [STEP_BITS-1:0]   s1_step_reg;
    hsl_side_t              s1_side_reg;

    // stage 2: sum and saturate
    logic [SW-1:0]          sum;
    logic                   sat2;
    logic [STEP_BITS-1:0]   step_next;
    logic [STEP_BITS-1:0]   s2_step_reg;
    logic                   s2_inner_reg;
    hsl_side_t              s2_side_reg;

    // stage 3: output register
    hsl_out_t               out_next;
    hsl_out_t               out_reg;

    assign adv  = ~v_reg[NS-1] | out_ready;
    assign en   = ~v_reg | {NS{adv}};
    assign take = {out_ready, en[NS-1:1]};

    assign v_next[0] = en[0] ? q_valid : (v_reg[0] & ~take[0]);
    for (genvar i = 1; i < NS; i++)
    begin : g_valid
        assign v_next[i] = en[i] ? v_reg[i-1] : (v_reg[i] & ~take[i]);
    end

    // inside the bounds the ratio is below one, so its fraction bits hold it
    assign inner     = q_side.distance < cfg.lag;
    assign qsum      = FX_W'(q_ratio[FRAC_BITS-1:0]) + FX_TENTH;
    assign qin       = (qsum > FX_ONE) ? FX_ONE : qsum;
    assign mop       = inner ? OPW'(qin) : q_ratio[OPW-1:0];
    assign prod_next = PW'(cfg.turn_rate) * PW'(mop);

    // outside: step = turn_rate * r * r >> 2F, computed as (turn_rate * r) * r
    assign t1        = s0_prod_reg[T1W-1:0];
    assign pl_next   = PLW'(t1) * PLW'(s0_rs_reg[H-1:0]);
    assign ph_next   = PHW'(t1) * PHW'(s0_rs_reg[OPW-1:H]);
    assign sat1_next = (s0_big_reg && (cfg.turn_rate != '0)) || (|s0_prod_reg[PW-1:T1W]);

    assign sum       = SW'(s1_pl_reg) + (SW'(s1_ph_reg) << H);
    assign sat2      = s1_sat_reg || (|sum[SW-1:2*FRAC_BITS+STEP_BITS]);
    assign step_next = s1_inner_reg ? s1_step_reg
                     : (sat2 ? STEP_MAX : sum[2*FRAC_BITS+STEP_BITS-1:2*FRAC_BITS]);

    always_comb
    begin
        out_next.reached = s2_step_reg >= s2_side_reg.distance;
        if (out_next.reached)
        begin
            out_next.new_heading = s2_side_reg.tgt;
        end
        else if (s2_side_reg.dec)
        begin
            out_next.new_heading = s2_side_reg.cur - s2_step_reg;
        end
        else
        begin
            out_next.new_heading = s2_side_reg.cur + s2_step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_prod_reg  <= prod_next;
            s0_inner_reg <= inner;
            s0_big_reg   <= |q_ratio[Q-1:OPW];
            s0_rs_reg    <= q_ratio[OPW-1:0];
            s0_side_reg  <= q_side;
        end
        if (en[1])
        begin
            s1_pl_reg    <= pl_next;
            s1_ph_reg    <= ph_next;
            s1_inner_reg <= s0_inner_reg;
            s1_sat_reg   <= sat1_next;
            s1_step_reg  <= s0_prod_reg[FRAC_BITS+STEP_BITS-1:FRAC_BITS];
            s1_side_reg  <= s0_side_reg;
        end
        if (en[2])
        begin
            s2_step_reg  <= step_next;
            s2_inner_reg <= s1_inner_reg;
            s2_side_reg  <= s1_side_reg;
        end
        if (en[3])
        begin
            out_reg      <= out_next;
        end
    end

    assign flow.adv  = adv;
    assign flow.take = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

    `HSL_ASSERT_NOW(step_inner_bounded, v_reg[2] && s2_inner_reg,
        s2_step_reg <= cfg.turn_rate, "inner step above turn rate")
    `HSL_ASSERT_NOW(step_inner_no_sat, v_reg[1] && s1_inner_reg,
        !s1_sat_reg, "saturation flagged inside lag bounds")
    `HSL_ASSERT_NOW(step_room_when_empty, !v_reg[NS-1],
        flow.adv && flow.take, "pipeline stalled with empty output register")

endmodule
